// ===== src/button_event_tracker_assert.svh =====
// ---------------------------------------------------------------------------
// button_event_tracker assertion macros
// clocked on clock, disabled while reset is high
// ---------------------------------------------------------------------------
`ifndef BUTTON_EVENT_TRACKER_ASSERT_SVH
`define BUTTON_EVENT_TRACKER_ASSERT_SVH

// consequent checked in the same cycle
`define BET_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the next cycle
`define BET_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/bet_pkg.sv =====
// ---------------------------------------------------------------------------
// bet_pkg
// types and constants shared by the button event tracker
// ---------------------------------------------------------------------------
package bet_pkg;

   localparam int TICK_WIDTH_DEFAULT  = 32;
   localparam int COUNT_WIDTH_DEFAULT = 32;

   localparam logic [15:0] TAP_TICKS_RESET = 16'd55;

   // power-key event byte
   localparam logic [7:0] EVT_MASK        = 8'h3C;
   localparam logic [7:0] EVT_PRESS_BIT   = 8'h20;
   localparam logic [7:0] EVT_RELEASE_BIT = 8'h10;
   localparam logic [7:0] EVT_SHORT_BIT   = 8'h04;
   localparam logic [7:0] EVT_LONG_BIT    = 8'h08;

   // request kinds
   localparam logic REQ_POLL  = 1'b0;
   localparam logic REQ_SYNTH = 1'b1;

   // synthetic button codes
   localparam logic [1:0] BTN_BOOT    = 2'd0;
   localparam logic [1:0] BTN_USER    = 2'd1;
   localparam logic [1:0] BTN_POWER   = 2'd2;
   localparam logic [1:0] BTN_INVALID = 2'd3;

   typedef struct packed {
      logic        req_type;
      logic [31:0] now_tick;
      logic        boot_level;
      logic        user_level;
      logic [7:0]  pmic_status;
      logic [1:0]  synth_button;
      logic [31:0] hold_ticks;
   } req_data_type;

   typedef struct packed {
      logic        boot_down;
      logic        user_down;
      logic        pwr_down;
      logic [31:0] boot_total;
      logic [31:0] user_total;
      logic [31:0] pwr_total;
      logic [7:0]  status_clear;
      logic        accepted;
   } rsp_data_type;

endpackage

// ===== src/button_event_tracker.sv =====
// ---------------------------------------------------------------------------
// button_event_tracker
// tracks boot, user and power buttons from poll and synthetic press requests
// ---------------------------------------------------------------------------
//  channel   | ports                          | direction
//  ----------+--------------------------------+----------
//  request   | req_valid, req_stall, req_data | in
//  response  | rsp_valid, rsp_stall, rsp_data | out
//  csr       | csr_wr_en, csr_wr_data         | in
//
//  one request per cycle while req_stall is low, one response per request:
//  the state update and the response are formed in the cycle of acceptance.
//  the response side has an output register plus one skid entry, so a
//  request is taken while one response waits; req_stall rises only when
//  both entries are full. synchronous reset clears all tracker state and
//  restores tap_ticks_ff to 55.
// ---------------------------------------------------------------------------
`include "button_event_tracker_assert.svh"

module button_event_tracker #(
   parameter int TICK_WIDTH  = bet_pkg::TICK_WIDTH_DEFAULT,
   parameter int COUNT_WIDTH = bet_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  bet_pkg::req_data_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output bet_pkg::rsp_data_type rsp_data,
   input  logic                  csr_wr_en,
   input  logic [15:0]           csr_wr_data
);

   localparam int SUM_WIDTH = (TICK_WIDTH > 33) ? TICK_WIDTH : 33;

   logic [15:0]            tap_ticks_ff;
   logic                   prev_boot_ff, prev_boot_in;
   logic                   prev_user_ff, prev_user_in;
   logic [COUNT_WIDTH-1:0] boot_cnt_ff, boot_cnt_in;
   logic [COUNT_WIDTH-1:0] user_cnt_ff, user_cnt_in;
   logic [COUNT_WIDTH-1:0] pwr_cnt_ff, pwr_cnt_in;
   logic                   boot_held_ff, boot_held_in;
   logic                   user_held_ff, user_held_in;
   logic                   pwr_held_ff, pwr_held_in;
   logic [TICK_WIDTH-1:0]  boot_end_ff, boot_end_in;
   logic [TICK_WIDTH-1:0]  user_end_ff, user_end_in;
   logic [TICK_WIDTH-1:0]  pwr_end_ff, pwr_end_in;

   logic                   rsp_valid_ff;
   logic                   skid_valid_ff;
   bet_pkg::rsp_data_type  rsp_data_ff;
   bet_pkg::rsp_data_type  skid_data_ff;
   bet_pkg::rsp_data_type  result;

   logic                   req_acc;
   logic                   rsp_take;
   logic [TICK_WIDTH-1:0]  now_t;
   logic [31:0]            window;
   logic [TICK_WIDTH-1:0]  end_tick;
   logic                   boot_dn, user_dn;
   logic [7:0]             evt;
   logic                   pwr_expired;
   logic                   pwr_active;
   logic [TICK_WIDTH-1:0]  pwr_end_mid;
   logic                   pwr_held_mid;
   logic                   ok;

   assign req_acc  = req_valid && !skid_valid_ff;
   assign rsp_take = rsp_valid_ff && !rsp_stall;

   assign now_t    = TICK_WIDTH'(req_data.now_tick);
   assign window   = (req_data.hold_ticks == 32'd0) ? 32'(tap_ticks_ff) : req_data.hold_ticks;
   assign end_tick = TICK_WIDTH'(SUM_WIDTH'(req_data.now_tick) + SUM_WIDTH'(window));
   assign boot_dn  = ~req_data.boot_level;
   assign user_dn  = ~req_data.user_level;
   assign evt      = req_data.pmic_status & bet_pkg::EVT_MASK;

   // power window expiry happens before the event byte is applied
   assign pwr_expired  = (pwr_end_ff != '0) && (now_t >= pwr_end_ff);
   assign pwr_end_mid  = pwr_expired ? '0 : pwr_end_ff;
   assign pwr_held_mid = pwr_expired ? 1'b0 : pwr_held_ff;
   assign pwr_active   = (pwr_end_mid != '0) && (now_t < pwr_end_mid);

   always_comb begin
      prev_boot_in = prev_boot_ff;
      prev_user_in = prev_user_ff;
      boot_cnt_in  = boot_cnt_ff;
      user_cnt_in  = user_cnt_ff;
      pwr_cnt_in   = pwr_cnt_ff;
      boot_held_in = boot_held_ff;
      user_held_in = user_held_ff;
      pwr_held_in  = pwr_held_ff;
      boot_end_in  = boot_end_ff;
      user_end_in  = user_end_ff;
      pwr_end_in   = pwr_end_ff;
      ok           = 1'b1;
      if (req_data.req_type == bet_pkg::REQ_POLL) begin
         if (boot_dn && !prev_boot_ff) begin
            boot_cnt_in = boot_cnt_ff + 1'b1;
         end
         if (user_dn && !prev_user_ff) begin
            user_cnt_in = user_cnt_ff + 1'b1;
         end
         prev_boot_in = boot_dn;
         prev_user_in = user_dn;
         if (now_t >= boot_end_ff) begin
            boot_held_in = boot_dn;
         end
         if (now_t >= user_end_ff) begin
            user_held_in = user_dn;
         end
         pwr_end_in  = pwr_end_mid;
         pwr_held_in = pwr_held_mid;
         if ((evt & (bet_pkg::EVT_PRESS_BIT | bet_pkg::EVT_SHORT_BIT
                     | bet_pkg::EVT_LONG_BIT)) != 8'd0) begin
            pwr_cnt_in = pwr_cnt_ff + 1'b1;
         end
         // release wins over press when both bits are set
         if (!pwr_active) begin
            if ((evt & bet_pkg::EVT_RELEASE_BIT) != 8'd0) begin
               pwr_held_in = 1'b0;
            end else if ((evt & bet_pkg::EVT_PRESS_BIT) != 8'd0) begin
               pwr_held_in = 1'b1;
            end
         end
      end else begin
         unique case (req_data.synth_button)
            bet_pkg::BTN_BOOT: begin
               boot_cnt_in  = boot_cnt_ff + 1'b1;
               boot_held_in = 1'b1;
               boot_end_in  = end_tick;
            end
            bet_pkg::BTN_USER: begin
               user_cnt_in  = user_cnt_ff + 1'b1;
               user_held_in = 1'b1;
               user_end_in  = end_tick;
            end
            bet_pkg::BTN_POWER: begin
               pwr_cnt_in  = pwr_cnt_ff + 1'b1;
               pwr_held_in = 1'b1;
               pwr_end_in  = end_tick;
            end
            default: begin
               ok = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      result.boot_down    = boot_held_in;
      result.user_down    = user_held_in;
      result.pwr_down     = pwr_held_in;
      result.boot_total   = 32'(boot_cnt_in);
      result.user_total   = 32'(user_cnt_in);
      result.pwr_total    = 32'(pwr_cnt_in);
      result.status_clear = (req_data.req_type == bet_pkg::REQ_POLL) ? evt : 8'd0;
      result.accepted     = ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_ticks_ff <= bet_pkg::TAP_TICKS_RESET;
      end else if (csr_wr_en) begin
         tap_ticks_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_boot_ff <= 1'b0;
         prev_user_ff <= 1'b0;
         boot_cnt_ff  <= '0;
         user_cnt_ff  <= '0;
         pwr_cnt_ff   <= '0;
         boot_held_ff <= 1'b0;
         user_held_ff <= 1'b0;
         pwr_held_ff  <= 1'b0;
         boot_end_ff  <= '0;
         user_end_ff  <= '0;
         pwr_end_ff   <= '0;
      end else if (req_acc) begin
         prev_boot_ff <= prev_boot_in;
         prev_user_ff <= prev_user_in;
         boot_cnt_ff  <= boot_cnt_in;
         user_cnt_ff  <= user_cnt_in;
         pwr_cnt_ff   <= pwr_cnt_in;
         boot_held_ff <= boot_held_in;
         user_held_ff <= user_held_in;
         pwr_held_ff  <= pwr_held_in;
         boot_end_ff  <= boot_end_in;
         user_end_ff  <= user_end_in;
         pwr_end_ff   <= pwr_end_in;
      end
   end

   // output register with one skid entry behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (rsp_take || !rsp_valid_ff) begin
            if (skid_valid_ff) begin
               rsp_valid_ff  <= 1'b1;
               skid_valid_ff <= 1'b0;
            end else begin
               rsp_valid_ff <= req_acc;
            end
         end else if (req_acc) begin
            skid_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_take || !rsp_valid_ff) begin
         if (skid_valid_ff) begin
            rsp_data_ff <= skid_data_ff;
         end else if (req_acc) begin
            rsp_data_ff <= result;
         end
      end else if (req_acc) begin
         skid_data_ff <= result;
      end
   end

   assign req_stall = skid_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `BET_ASSERT_SAME(a_skid_behind_main, skid_valid_ff, rsp_valid_ff, "skid full with empty output")
   `BET_ASSERT_NEXT(a_stalled_accept_skids, req_acc && rsp_valid_ff && rsp_stall, skid_valid_ff, "stalled accept not held in skid")
   `BET_ASSERT_NEXT(a_pwr_window_closes, req_acc && (req_data.req_type == bet_pkg::REQ_POLL) && pwr_expired, pwr_end_ff == '0, "power window not closed on expiry")

endmodule

// ===== sim/button_tracker_checker.sv =====
// ----------------------------------------------------------------------------
// button_tracker_checker
// Watches the request, response and csr ports of the button event tracker.
// It keeps its own copy of the tracker state and the tap length, and works
// out the response for every accepted request. Each accepted response is
// compared field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module button_tracker_checker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  bet_pkg::req_data_type req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  bet_pkg::rsp_data_type rsp_data,
   input  logic                  csr_wr_en,
   input  logic [15:0]           csr_wr_data,
   output int unsigned           fail_count,
   output int unsigned           pending
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [15:0] tap_ticks;
   logic        boot_was_down, user_was_down;
   logic [31:0] boot_presses, user_presses, power_presses;
   logic        boot_held, user_held, power_held;
   logic [31:0] boot_hold_end, user_hold_end, power_hold_end;

   bet_pkg::rsp_data_type button_reports[$];

   task automatic track_request(input bet_pkg::req_data_type r,
                                output bet_pkg::rsp_data_type o);
      logic        boot_down;
      logic        user_down;
      logic        override_on;
      logic [7:0]  evt;
      logic [31:0] window;
      logic [31:0] win_end;
      begin
         o = '0;
         o.accepted = 1'b1;
         if (r.req_type == bet_pkg::REQ_POLL) begin
            boot_down = !r.boot_level;
            user_down = !r.user_level;
            evt = r.pmic_status & bet_pkg::EVT_MASK;
            if (boot_down && !boot_was_down) boot_presses = boot_presses + 32'd1;
            if (user_down && !user_was_down) user_presses = user_presses + 32'd1;
            boot_was_down = boot_down;
            user_was_down = user_down;
            if (r.now_tick >= boot_hold_end) boot_held = boot_down;
            if (r.now_tick >= user_hold_end) user_held = user_down;
            // power window expiry
            if (power_hold_end != 0 && r.now_tick >= power_hold_end) begin
               power_held = 1'b0;
               power_hold_end = '0;
            end
            if (evt != 0) begin
               if ((evt & (bet_pkg::EVT_PRESS_BIT | bet_pkg::EVT_SHORT_BIT
                           | bet_pkg::EVT_LONG_BIT)) != 0)
                  power_presses = power_presses + 32'd1;
               override_on = power_hold_end != 0 && r.now_tick < power_hold_end;
               if (!override_on) begin
                  if ((evt & bet_pkg::EVT_PRESS_BIT) != 0) power_held = 1'b1;
                  if ((evt & bet_pkg::EVT_RELEASE_BIT) != 0) power_held = 1'b0;
               end
               o.status_clear = evt;
            end
         end else begin
            window = (r.hold_ticks == 0) ? {16'd0, tap_ticks} : r.hold_ticks;
            win_end = r.now_tick + window;
            case (r.synth_button)
               bet_pkg::BTN_BOOT: begin
                  boot_presses = boot_presses + 32'd1;
                  boot_held = 1'b1;
                  boot_hold_end = win_end;
               end
               bet_pkg::BTN_USER: begin
                  user_presses = user_presses + 32'd1;
                  user_held = 1'b1;
                  user_hold_end = win_end;
               end
               bet_pkg::BTN_POWER: begin
                  power_presses = power_presses + 32'd1;
                  power_held = 1'b1;
                  power_hold_end = win_end;
               end
               default: o.accepted = 1'b0;
            endcase
         end
         o.boot_down = boot_held;
         o.user_down = user_held;
         o.pwr_down = power_held;
         o.boot_total = boot_presses;
         o.user_total = user_presses;
         o.pwr_total = power_presses;
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s expected %0h got %0h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      bet_pkg::rsp_data_type predicted;
      bet_pkg::rsp_data_type oldest;
      if (reset) begin
         tap_ticks = bet_pkg::TAP_TICKS_RESET;
         boot_was_down = 1'b0;
         user_was_down = 1'b0;
         boot_presses = '0;
         user_presses = '0;
         power_presses = '0;
         boot_held = 1'b0;
         user_held = 1'b0;
         power_held = 1'b0;
         boot_hold_end = '0;
         user_hold_end = '0;
         power_hold_end = '0;
         button_reports.delete();
         pending <= 0;
      end else begin
         if (csr_wr_en) tap_ticks = csr_wr_data;
         if (req_valid && !req_stall) begin
            track_request(req_data, predicted);
            button_reports.push_back(predicted);
         end
         if (rsp_valid && !rsp_stall) begin
            if (button_reports.size() == 0) begin
               $error("response with no request outstanding");
               fail_count++;
            end else begin
               oldest = button_reports.pop_front();
               check_field("boot_down", 32'(oldest.boot_down), 32'(rsp_data.boot_down));
               check_field("user_down", 32'(oldest.user_down), 32'(rsp_data.user_down));
               check_field("pwr_down", 32'(oldest.pwr_down), 32'(rsp_data.pwr_down));
               check_field("boot_total", oldest.boot_total, rsp_data.boot_total);
               check_field("user_total", oldest.user_total, rsp_data.user_total);
               check_field("pwr_total", oldest.pwr_total, rsp_data.pwr_total);
               check_field("status_clear", 32'(oldest.status_clear),
                           32'(rsp_data.status_clear));
               check_field("accepted", 32'(oldest.accepted), 32'(rsp_data.accepted));
            end
         end
         pending <= button_reports.size();
      end
   end

endmodule

// ===== sim/button_event_tracker_tb.sv =====
// ----------------------------------------------------------------------------
// button_event_tracker_tb
// Drives poll and synthetic press requests into the button event tracker:
// a directed pass over the event bits, override windows and tick wrap, then
// random phases under several tap lengths with random idling on both sides.
// The checker beside the block predicts and compares; this module only makes
// stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module button_event_tracker_tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   bet_pkg::req_data_type req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   bet_pkg::rsp_data_type rsp_data;
   logic                  csr_wr_en = 1'b0;
   logic [15:0]           csr_wr_data = '0;

   int unsigned fail_count;
   int unsigned pending;

   bit          quiet = 1'b0;
   logic [31:0] tick_now = '0;
   logic        boot_lvl = 1'b1;
   logic        user_lvl = 1'b1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   button_event_tracker dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   button_tracker_checker checker_inst (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   always @(posedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(99) < 17);
   end

   function automatic bet_pkg::req_data_type poll_req(input logic [31:0] tick,
                                                      input logic boot,
                                                      input logic user,
                                                      input logic [7:0] status);
      bet_pkg::req_data_type r;
      r = '0;
      r.req_type = bet_pkg::REQ_POLL;
      r.now_tick = tick;
      r.boot_level = boot;
      r.user_level = user;
      r.pmic_status = status;
      return r;
   endfunction

   function automatic bet_pkg::req_data_type synth_req(input logic [31:0] tick,
                                                       input logic [1:0] button,
                                                       input logic [31:0] hold);
      bet_pkg::req_data_type r;
      r = '0;
      r.req_type = bet_pkg::REQ_SYNTH;
      r.now_tick = tick;
      r.boot_level = 1'b1;
      r.user_level = 1'b1;
      r.synth_button = button;
      r.hold_ticks = hold;
      return r;
   endfunction

   task automatic send_request(input bet_pkg::req_data_type r);
      req_data <= r;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (!quiet && $urandom_range(99) < 20) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic write_tap(input logic [15:0] value);
      csr_wr_data <= value;
      csr_wr_en <= 1'b1;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic random_phase(input int count);
      bet_pkg::req_data_type r;
      int pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         // mostly a forward-running tick, with rare jumps and near-wrap values
         if (pick < 3) tick_now = $urandom;
         else if (pick < 6) tick_now = 32'hFFFF_FF00 + $urandom_range(255);
         else tick_now = tick_now + $urandom_range(0, 40);
         if ($urandom_range(99) < 25) boot_lvl = ~boot_lvl;
         if ($urandom_range(99) < 25) user_lvl = ~user_lvl;
         r.req_type = ($urandom_range(99) < 30) ? bet_pkg::REQ_SYNTH : bet_pkg::REQ_POLL;
         r.now_tick = tick_now;
         r.boot_level = boot_lvl;
         r.user_level = user_lvl;
         pick = $urandom_range(99);
         if (pick < 55) r.pmic_status = 8'h00;
         else if (pick < 85) r.pmic_status = 8'h01 << $urandom_range(7);
         else r.pmic_status = 8'($urandom);
         r.synth_button = ($urandom_range(9) == 0) ? bet_pkg::BTN_INVALID
                                                   : 2'($urandom_range(2));
         pick = $urandom_range(99);
         if (pick < 30) r.hold_ticks = '0;
         else if (pick < 85) r.hold_ticks = $urandom_range(1, 200);
         else if (pick < 95) r.hold_ticks = $urandom_range(1, 65535);
         else r.hold_ticks = $urandom;
         send_request(r);
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // event byte decoding with the power override closed
      send_request(poll_req(32'd0, 1'b1, 1'b1, 8'h00));
      send_request(poll_req(32'd10, 1'b0, 1'b1, 8'h00));
      send_request(poll_req(32'd20, 1'b0, 1'b0, 8'hFF));
      send_request(poll_req(32'd30, 1'b1, 1'b1, bet_pkg::EVT_PRESS_BIT));
      send_request(poll_req(32'd40, 1'b1, 1'b1, bet_pkg::EVT_RELEASE_BIT));
      send_request(poll_req(32'd50, 1'b1, 1'b1, bet_pkg::EVT_SHORT_BIT));
      send_request(poll_req(32'd60, 1'b1, 1'b1, bet_pkg::EVT_LONG_BIT));
      send_request(poll_req(32'd70, 1'b1, 1'b1, ~bet_pkg::EVT_MASK));
      // default tap window on boot, held through and then released
      send_request(synth_req(32'd100, bet_pkg::BTN_BOOT, 32'd0));
      send_request(poll_req(32'd120, 1'b1, 1'b1, 8'h00));
      send_request(poll_req(32'd155, 1'b1, 1'b1, 8'h00));
      send_request(synth_req(32'd200, bet_pkg::BTN_USER, 32'd1000));
      send_request(poll_req(32'd500, 1'b0, 1'b0, 8'h00));
      // power override masks press and release events until it expires
      send_request(synth_req(32'd600, bet_pkg::BTN_POWER, 32'd0));
      send_request(poll_req(32'd610, 1'b1, 1'b1, bet_pkg::EVT_RELEASE_BIT));
      send_request(poll_req(32'd620, 1'b1, 1'b1, bet_pkg::EVT_PRESS_BIT));
      send_request(poll_req(32'd700, 1'b1, 1'b1, 8'h00));
      send_request(synth_req(32'd800, bet_pkg::BTN_INVALID, 32'd5));
      // window ends that wrap, one of them to zero
      send_request(synth_req(32'hFFFF_FFF0, bet_pkg::BTN_POWER, 32'h10));
      send_request(poll_req(32'hFFFF_FFFF, 1'b1, 1'b1, bet_pkg::EVT_RELEASE_BIT));
      send_request(synth_req(32'hFFFF_FFFF, bet_pkg::BTN_BOOT, 32'hFFFF_FFFF));
      send_request(poll_req(32'hFFFF_FFFF, 1'b0, 1'b1, 8'h00));
      send_request(synth_req(32'h5555_AAAA, bet_pkg::BTN_USER, 32'hAAAA_5555));
      send_request(poll_req(32'hAAAA_5555, 1'b1, 1'b0, 8'h55));

      wait_drained();
      write_tap(16'd0);
      random_phase(175);

      wait_drained();
      write_tap(16'hFFFF);
      quiet <= 1'b1;
      random_phase(175);
      quiet <= 1'b0;

      wait_drained();
      write_tap(16'($urandom_range(65535)));
      random_phase(90);
      wait_drained();
      random_phase(85);

      wait_drained();
      write_tap(bet_pkg::TAP_TICKS_RESET);
      random_phase(175);

      wait_drained();
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
